@@ design/oct_pkg.sv @@
// ----------------------------------------------------------------------------
// oct_pkg
// Shared types and constants for the octahedral normal encoder pipeline.
// ----------------------------------------------------------------------------
package oct_pkg;

  // quotient bits: value * 2^16 / l1, later rounded to 2^15 scale
  localparam int QBITS = 17;
  // divider steps per pipeline stage
  localparam int STEP = 4;
  localparam int NSTG = (QBITS + STEP - 1) / STEP;

  localparam logic [15:0] SNORM_MAX = 16'h7fff;
  localparam logic [16:0] SNORM_NEG_MAX = 17'h08000;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
    logic hand;
  } ctrl_t;

endpackage

@@ design/octahedral_normal_encoder.sv @@
// ----------------------------------------------------------------------------
// octahedral_normal_encoder
// Signed 3-vector to 32-bit octahedral code (snorm16 u low, v high).
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while the output is not stalled (one prep
// stage, five restoring-divider stages of up to four quotient bits each, one
// output stage). The two 17-bit divisions by the L1 norm set the depth.
// A stall on the output freezes the whole pipeline. cfg_ready is always high.
module octahedral_normal_encoder
  import oct_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [COMPONENT_WIDTH-1:0] in_comp_x,
  input  logic [COMPONENT_WIDTH-1:0] in_comp_y,
  input  logic [COMPONENT_WIDTH-1:0] in_comp_z,
  input  logic                       in_handedness_negative,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_packed_code,
  output logic                       out_zero_vector
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int DW = W + 2;

  logic            mode_r;
  logic [NSTG:0]   vld_r;
  ctrl_t           ctrl_r [NSTG+1];
  logic            adv;
  logic            out_valid_r;
  logic [31:0]     code_r;
  logic            zero_r;

  logic [DW:0]      rem_u [NSTG+1];
  logic [DW:0]      rem_v [NSTG+1];
  logic [DW-1:0]    den_u [NSTG+1];
  logic [DW-1:0]    den_v [NSTG+1];
  logic [QBITS-1:0] q_u   [NSTG+1];
  logic [QBITS-1:0] q_v   [NSTG+1];

  logic [W-1:0]  ax, ay, az;
  logic [DW-1:0] l1, nu, nv;
  ctrl_t         ctrl_in;
  logic [31:0]   code_nxt;
  logic          zero_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  always_comb begin
    ax = in_comp_x[W-1] ? W'(-in_comp_x) : in_comp_x;
    ay = in_comp_y[W-1] ? W'(-in_comp_y) : in_comp_y;
    az = in_comp_z[W-1] ? W'(-in_comp_z) : in_comp_z;
    l1 = DW'(ax) + DW'(ay) + DW'(az);
    nu = in_comp_z[W-1] ? DW'(ax) + DW'(az) : DW'(ax);
    nv = in_comp_z[W-1] ? DW'(ay) + DW'(az) : DW'(ay);
    ctrl_in.neg_x = in_comp_x[W-1];
    ctrl_in.neg_y = in_comp_y[W-1];
    ctrl_in.zero  = (l1 == '0);
    ctrl_in.hand  = in_handedness_negative;
  end

  // prep stage
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_u[0]  <= {1'b0, nu};
      rem_v[0]  <= {1'b0, nv};
      den_u[0]  <= l1;
      den_v[0]  <= l1;
      q_u[0]    <= '0;
      q_v[0]    <= '0;
      ctrl_r[0] <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:0], in_valid};
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_div
    localparam int LEFT = QBITS - k * STEP;
    localparam int NS   = (LEFT < STEP) ? LEFT : STEP;

    oct_div_stage #(.DW(DW), .NSTEPS(NS)) u_div_u (
      .clk   (clk),
      .en    (adv),
      .rem_i (rem_u[k]),
      .den_i (den_u[k]),
      .q_i   (q_u[k]),
      .rem_r (rem_u[k+1]),
      .den_r (den_u[k+1]),
      .q_r   (q_u[k+1])
    );

    oct_div_stage #(.DW(DW), .NSTEPS(NS)) u_div_v (
      .clk   (clk),
      .en    (adv),
      .rem_i (rem_v[k]),
      .den_i (den_v[k]),
      .q_i   (q_v[k]),
      .rem_r (rem_v[k+1]),
      .den_r (den_v[k+1]),
      .q_r   (q_v[k+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        ctrl_r[k+1] <= ctrl_r[k];
      end
    end
  end

  oct_pack u_pack (
    .q_u  (q_u[NSTG]),
    .q_v  (q_v[NSTG]),
    .ctrl (ctrl_r[NSTG]),
    .mode (mode_r),
    .code (code_nxt),
    .zero (zero_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code_r <= code_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_code = code_r;
  assign out_zero_vector = zero_r;

`ifndef SYNTH
  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |-> out_packed_code[31:1] == 31'd0)
    else $error("zero vector with nonzero code");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && vld_r == '0)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG] && !adv |=> vld_r[NSTG] && $stable(q_u[NSTG]) && $stable(q_v[NSTG]))
    else $error("divider output changed during stall");
`endif

endmodule

@@ design/oct_div_stage.sv @@
// ----------------------------------------------------------------------------
// oct_div_stage
// A few restoring-division steps followed by a pipeline register.
// ----------------------------------------------------------------------------
module oct_div_stage
  import oct_pkg::*;
#(
  parameter int DW     = 18,
  parameter int NSTEPS = 4
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DW:0]          rem_i,
  input  logic [DW-1:0]        den_i,
  input  logic [QBITS-1:0]     q_i,
  output logic [DW:0]          rem_r,
  output logic [DW-1:0]        den_r,
  output logic [QBITS-1:0]     q_r
);

  logic [DW:0]      rem_nxt;
  logic [QBITS-1:0] q_nxt;

  always_comb begin
    logic [DW:0] d;
    d       = {1'b0, den_i};
    rem_nxt = rem_i;
    q_nxt   = q_i;
    for (int i = 0; i < NSTEPS; i++) begin
      if (rem_nxt >= d) begin
        rem_nxt = rem_nxt - d;
        q_nxt   = {q_nxt[QBITS-2:0], 1'b1};
      end else begin
        q_nxt   = {q_nxt[QBITS-2:0], 1'b0};
      end
      rem_nxt = {rem_nxt[DW-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
    end
  end

endmodule

@@ design/oct_pack.sv @@
// ----------------------------------------------------------------------------
// oct_pack
// Rounding, sign, clamp and packing of the two quotients into the code; with mode set, bit 0 carries the handedness.
// ----------------------------------------------------------------------------
module oct_pack
  import oct_pkg::*;
(
  input  logic [QBITS-1:0] q_u,
  input  logic [QBITS-1:0] q_v,
  input  ctrl_t            ctrl,
  input  logic             mode,
  output logic [31:0]      code,
  output logic             zero
);

  function automatic logic [15:0] snorm(input logic [QBITS-1:0] q, input logic neg);
    logic [16:0] m;
    m = 17'((18'(q) + 18'd1) >> 1);
    if (neg) begin
      if (m > SNORM_NEG_MAX) m = SNORM_NEG_MAX;
      snorm = 16'(17'd0 - m);
    end else begin
      snorm = (m > {1'b0, SNORM_MAX}) ? SNORM_MAX : m[15:0];
    end
  endfunction

  logic [31:0] dir;

  always_comb begin
    dir  = ctrl.zero ? 32'd0 : {snorm(q_v, ctrl.neg_y), snorm(q_u, ctrl.neg_x)};
    code = mode ? {dir[31:1], ctrl.hand} : dir;
    zero = ctrl.zero;
  end

endmodule

@@ test/oct_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oct_checker
// Watches the input, configuration and result channels of the octahedral
// encoder. It predicts each code from the accepted vector and the current
// mode, and compares every result against the oldest prediction in order.
// ----------------------------------------------------------------------------
module oct_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_comp_x,
  input  logic [15:0] in_comp_y,
  input  logic [15:0] in_comp_z,
  input  logic        in_handedness_negative,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_packed_code,
  input  logic        out_zero_vector,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] code;
    logic        zero;
  } oct_code_t;

  oct_code_t code_q[$];
  logic tangent_mode;

  // round(m * 32768 / l1) half away from zero, sign applied, clamped
  function automatic logic [15:0] snorm_half(longint m, longint l1, bit neg);
    longint r;
    r = ((m << 16) + l1) / (2 * l1);
    if (neg) begin
      if (r > 32768) r = 32768;
      return 16'(65536 - r);
    end
    if (r > 32767) r = 32767;
    return 16'(r);
  endfunction

  function automatic oct_code_t encode_vector(logic [15:0] xr, logic [15:0] yr,
                                             logic [15:0] zr, logic hand,
                                             logic tmode);
    longint x, y, z, ax, ay, az, l1;
    oct_code_t res;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    z = longint'($signed(zr));
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    l1 = ax + ay + az;
    res.code = '0;
    res.zero = (l1 == 0);
    if (l1 != 0) begin
      if (z < 0)
        res.code = {snorm_half(ay + az, l1, y < 0), snorm_half(ax + az, l1, x < 0)};
      else
        res.code = {snorm_half(ay, l1, y < 0), snorm_half(ax, l1, x < 0)};
    end
    if (tmode) res.code[0] = hand;
    return res;
  endfunction

  assign pending = code_q.size();

  always @(posedge clk) begin
    oct_code_t e;
    int errs;
    if (!rst_n) begin
      tangent_mode <= 1'b0;
      fail_count <= 0;
      code_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) tangent_mode <= cfg_data;
      if (in_valid && in_ready)
        code_q.push_back(encode_vector(in_comp_x, in_comp_y, in_comp_z,
                                       in_handedness_negative, tangent_mode));
      if (out_valid && out_ready) begin
        if (code_q.size() == 0) begin
          $error("unexpected item: code %h zero %b", out_packed_code, out_zero_vector);
          fail_count <= fail_count + 1;
        end else begin
          e = code_q.pop_front();
          errs = 0;
          if (out_packed_code !== e.code) begin
            $error("packed_code expected %h actual %h", e.code, out_packed_code);
            errs = errs + 1;
          end
          if (out_zero_vector !== e.zero) begin
            $error("zero_vector expected %b actual %b", e.zero, out_zero_vector);
            errs = errs + 1;
          end
          fail_count <= fail_count + errs;
        end
      end
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random vectors through the octahedral encoder in both
// modes, with and without random sender and receiver idling, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_comp_x;
  logic [15:0] in_comp_y;
  logic [15:0] in_comp_z;
  logic        in_handedness_negative;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_packed_code;
  logic        out_zero_vector;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;

  octahedral_normal_encoder #(.COMPONENT_WIDTH(16)) dut (.*);

  oct_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays high after an accept so items can follow back to back
  task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_comp_x <= x;
    in_comp_y <= y;
    in_comp_z <= z;
    in_handedness_negative <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000 + 16'($urandom_range(3));
      1: return 16'h7fff - 16'($urandom_range(3));
      2: return 16'($signed(16'($urandom_range(8))) - 16'sd4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++)
      send_vector(rand_comp(), rand_comp(), rand_comp(), 1'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_comp_x = '0;
    in_comp_y = '0;
    in_comp_z = '0;
    in_handedness_negative = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 54;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero vector, axes, fold, signed zeros
    send_vector(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_vector(16'h7fff, 16'h0000, 16'h0000, 1'b0);
    send_vector(16'h8000, 16'h0000, 16'h0000, 1'b1);
    send_vector(16'h0000, 16'h7fff, 16'h0000, 1'b0);
    send_vector(16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_vector(16'h0000, 16'h0000, 16'h7fff, 1'b1);
    send_vector(16'h0000, 16'h0000, 16'h8000, 1'b0);
    send_vector(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_vector(16'h0001, 16'hffff, 16'hffff, 1'b1);
    send_vector(16'h0000, 16'h0001, 16'hffff, 1'b0);
    send_vector(16'hffff, 16'h0000, 16'hfffe, 1'b1);
    send_vector(16'h0001, 16'h0002, 16'h0000, 1'b0);
    send_vector(16'h0001, 16'h0001, 16'h0001, 1'b1);
    send_vector(16'h5555, 16'haaaa, 16'h0001, 1'b0);
    random_run(130);
    drain_pipe();

    write_mode(1'b1);
    send_vector(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_vector(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_vector(16'h7fff, 16'h0000, 16'h0000, 1'b0);
    send_vector(16'h8000, 16'h0000, 16'h8000, 1'b1);
    send_idle_pct = 54;
    recv_idle_pct = 34;
    random_run(150);
    drain_pipe();

    write_mode(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_run(80);
    drain_pipe();
    write_mode(1'b1);
    random_run(80);
    drain_pipe();

    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
